// ===== sv/mcet_pkg.sv =====
`timescale 1ns / 1ps

package mcet_pkg;

   localparam int CHANNELS_DEF = 16;

   localparam int TICK_W = 24;
   localparam int WRAP_W = 16;
   localparam int TPU_W  = 8;
   localparam int CH_IN_W = 4;
   localparam int NEED_W = TICK_W + TPU_W;
   localparam int CSR_IDX_W = 1;

   localparam logic [TPU_W-1:0]  TPU_RESET    = 8'd168;
   localparam logic [TICK_W-1:0] THRESH_RESET = 24'd90000;
   localparam logic [WRAP_W-1:0] WRAP_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_CHECK     = 2'd0,
      MODE_READ      = 2'd1,
      MODE_CLEAR_ONE = 2'd2,
      MODE_CLEAR_ALL = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_US = 1'd0,
      CSR_LONG_THRESH  = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0] start_tick;
      logic [TICK_W-1:0] last_sample_tick;
      logic [WRAP_W-1:0] wrap_count;
   } chan_type;

endpackage

// ===== sv/mcet_ram.sv =====
`timescale 1ns / 1ps

module mcet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/multi_channel_elapsed_timer.sv =====
`timescale 1ns / 1ps
// check and single-channel reset: result registered after the S_READ and S_EXEC states
// read: elapsed ticks go through the 24-step bit-serial divider by ticks_per_us
// reset all: one channel memory write per cycle until every channel is written
// one item at a time; busy stays high until the result is registered
// synchronous reset: control and CSR registers to defaults, every channel reads as zero

module multi_channel_elapsed_timer
   import mcet_pkg::*;
#(
   parameter int CHANNELS = CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_mode,
   input  logic [CH_IN_W-1:0]   req_channel,
   input  logic [TICK_W-1:0]    req_interval_us,
   input  logic [TICK_W-1:0]    req_tick_now,
   output logic                 rsp_valid,
   output logic                 rsp_interval_done,
   output logic [TICK_W-1:0]    rsp_elapsed_us,
   output logic [TPU_W-1:0]     rsp_elapsed_rem_ticks,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_data
);

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIV_STEPS = TICK_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int LONG_W = WRAP_W + TICK_W + 2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_DIV,
      S_SWEEP
   } state_type;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [CH_IN_W-1:0]   ch_ff, ch_in;
   logic [TICK_W-1:0]    interval_ff, interval_in;
   logic [TICK_W-1:0]    now_ff, now_in;
   logic [NEED_W-1:0]    need_ff, need_in;
   logic [TPU_W-1:0]     tpu_ff, tpu_in;
   logic [TICK_W-1:0]    thresh_ff, thresh_in;
   logic [CHANNELS-1:0]  valid_ff, valid_in;
   logic [CH_W-1:0]      sweep_ff, sweep_in;
   logic [TICK_W-1:0]    div_q_ff, div_q_in;
   logic [TPU_W-1:0]     div_r_ff, div_r_in;
   logic [TPU_W-1:0]     div_d_ff, div_d_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic [TICK_W-1:0]    rsp_us_ff, rsp_us_in;
   logic [TPU_W-1:0]     rsp_rem_ff, rsp_rem_in;

   logic [TPU_W-1:0]     eff_tpu;
   logic [8:0]           ch_wide;
   logic [CH_W-1:0]      ch_idx;
   logic                 req_in_range;
   chan_type             rd_raw;
   chan_type             entry;
   logic                 ram_wr_en;
   logic [CH_W-1:0]      ram_wr_addr;
   chan_type             ram_wr_data;
   logic [WRAP_W-1:0]    wrap_inc;
   logic signed [LONG_W-1:0] el_long;
   logic [TICK_W-1:0]    el_short;
   logic                 is_long;
   logic                 done_long;
   logic                 done_short;
   logic [TPU_W:0]       div_shift;
   logic [TPU_W-1:0]     div_r_next;
   logic [TICK_W-1:0]    div_q_next;

   mcet_ram #(
      .WIDTH ($bits(chan_type)),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ch_idx),
      .rd_data (rd_raw)
   );

   assign eff_tpu = (tpu_ff == '0) ? TPU_W'(1) : tpu_ff;
   assign ch_wide = 9'(ch_ff);
   assign ch_idx = ch_wide[CH_W-1:0];
   assign req_in_range = 9'(req_channel) < 9'(CHANNELS);

   // a channel never written since reset reads as zero
   assign entry = valid_ff[ch_idx] ? rd_raw : '0;

   assign is_long = interval_ff > thresh_ff;
   assign wrap_inc = (entry.last_sample_tick < now_ff && entry.wrap_count != WRAP_MAX)
                     ? entry.wrap_count + WRAP_W'(1) : entry.wrap_count;
   assign el_long = $signed({2'b00, wrap_inc, entry.start_tick})
                    - $signed(LONG_W'(now_ff));
   assign done_long = el_long >= $signed(LONG_W'(need_ff));
   assign el_short = entry.start_tick - now_ff;
   assign done_short = NEED_W'(el_short) >= need_ff;

   // restoring division, one quotient bit a step
   assign div_shift = {div_r_ff, div_q_ff[TICK_W-1]};
   assign div_r_next = (div_shift >= {1'b0, div_d_ff})
                       ? TPU_W'(div_shift - {1'b0, div_d_ff}) : div_shift[TPU_W-1:0];
   assign div_q_next = {div_q_ff[TICK_W-2:0], (div_shift >= {1'b0, div_d_ff})};

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      ch_in        = ch_ff;
      interval_in  = interval_ff;
      now_in       = now_ff;
      need_in      = need_ff;
      tpu_in       = tpu_ff;
      thresh_in    = thresh_ff;
      valid_in     = valid_ff;
      sweep_in     = sweep_ff;
      div_q_in     = div_q_ff;
      div_r_in     = div_r_ff;
      div_d_in     = div_d_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_done_in  = rsp_done_ff;
      rsp_us_in    = rsp_us_ff;
      rsp_rem_in   = rsp_rem_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ch_idx;
      ram_wr_data  = entry;

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_TICKS_PER_US: tpu_in = csr_data[TPU_W-1:0];
            CSR_LONG_THRESH:  thresh_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in     = mode_type'(req_mode);
               ch_in       = req_channel;
               interval_in = req_interval_us;
               now_in      = req_tick_now;
               need_in     = NEED_W'(req_interval_us) * NEED_W'(eff_tpu);
               if (mode_type'(req_mode) == MODE_CLEAR_ALL) begin
                  sweep_in = '0;
                  state_in = S_SWEEP;
               end else if (req_in_range) begin
                  state_in = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_done_in  = 1'b0;
                  rsp_us_in    = '0;
                  rsp_rem_in   = '0;
               end
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ram_wr_en          = 1'b1;
            valid_in[ch_idx]   = 1'b1;
            rsp_done_in        = 1'b0;
            rsp_us_in          = '0;
            rsp_rem_in         = '0;
            state_in           = S_IDLE;
            rsp_valid_in       = 1'b1;
            unique case (mode_ff)
               MODE_CHECK: begin
                  if (is_long) begin
                     rsp_done_in = done_long;
                     if (done_long) begin
                        ram_wr_data = '{now_ff, now_ff, '0};
                     end else begin
                        ram_wr_data = '{entry.start_tick, now_ff, wrap_inc};
                     end
                  end else begin
                     rsp_done_in = done_short;
                     ram_wr_data = '{done_short ? now_ff : entry.start_tick, now_ff, '0};
                  end
               end
               MODE_READ: begin
                  ram_wr_data  = '{now_ff, entry.last_sample_tick, entry.wrap_count};
                  div_q_in     = el_short;
                  div_r_in     = '0;
                  div_d_in     = eff_tpu;
                  div_cnt_in   = '0;
                  rsp_valid_in = 1'b0;
                  state_in     = S_DIV;
               end
               default: begin
                  ram_wr_data = '{now_ff, now_ff, '0};
               end
            endcase
         end
         S_DIV: begin
            div_q_in   = div_q_next;
            div_r_in   = div_r_next;
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_us_in    = div_q_next;
               rsp_rem_in   = div_r_next;
               state_in     = S_IDLE;
            end
         end
         S_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '{now_ff, now_ff, '0};
            sweep_in    = sweep_ff + CH_W'(1);
            if (sweep_ff == CH_W'(CHANNELS - 1)) begin
               valid_in     = '1;
               rsp_valid_in = 1'b1;
               rsp_done_in  = 1'b0;
               rsp_us_in    = '0;
               rsp_rem_in   = '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tpu_ff       <= TPU_RESET;
         thresh_ff    <= THRESH_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tpu_ff       <= tpu_in;
         thresh_ff    <= thresh_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      ch_ff       <= ch_in;
      interval_ff <= interval_in;
      now_ff      <= now_in;
      need_ff     <= need_in;
      sweep_ff    <= sweep_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_d_ff    <= div_d_in;
      div_cnt_ff  <= div_cnt_in;
      rsp_done_ff <= rsp_done_in;
      rsp_us_ff   <= rsp_us_in;
      rsp_rem_ff  <= rsp_rem_in;
   end

   assign busy                  = state_ff != S_IDLE;
   assign csr_ready             = 1'b1;
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_interval_done     = rsp_done_ff;
   assign rsp_elapsed_us        = rsp_us_ff;
   assign rsp_elapsed_rem_ticks = rsp_rem_ff;

endmodule

// ===== tb/multi_channel_elapsed_timer_tb.sv =====
`timescale 1ns / 1ps

module multi_channel_elapsed_timer_tb
   import mcet_pkg::*;
();

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 245;
   localparam int PHASES = 7;
   localparam logic [TICK_W-1:0] TICK_TOP = '1;
   localparam logic [TPU_W-1:0] PHASE_RATE [PHASES] =
      '{8'd168, 8'd1, 8'd255, 8'd0, 8'd12, 8'd3, 8'd99};
   localparam logic [TICK_W-1:0] PHASE_THRESH [PHASES] =
      '{24'd90000, 24'd0, 24'hFFFFFF, 24'd100, 24'd0, 24'd5000, 24'd0};

   typedef struct {
      logic              done;
      logic [TICK_W-1:0] whole_us;
      logic [TPU_W-1:0]  rem_ticks;
   } timing_type;

   class timer_scoreboard;
      logic [TICK_W-1:0] chan_start [CHANNELS_DEF];
      logic [TICK_W-1:0] chan_last [CHANNELS_DEF];
      logic [WRAP_W-1:0] chan_wraps [CHANNELS_DEF];
      logic [TPU_W-1:0]  ticks_per_us;
      logic [TICK_W-1:0] long_thresh;
      timing_type        due_timings [$];
      int                errors;

      function new();
         ticks_per_us = TPU_RESET;
         long_thresh = THRESH_RESET;
         errors = 0;
         foreach (chan_start[i]) begin
            chan_start[i] = '0;
            chan_last[i] = '0;
            chan_wraps[i] = '0;
         end
      endfunction

      function void set_register(csr_index_type idx, logic [TICK_W-1:0] value);
         if (idx == CSR_TICKS_PER_US) begin
            ticks_per_us = value[TPU_W-1:0];
         end else begin
            long_thresh = value;
         end
      endfunction

      function void restart_chan(int ch, logic [TICK_W-1:0] now);
         chan_start[ch] = now;
         chan_last[ch] = now;
         chan_wraps[ch] = '0;
      endfunction

      // works out the timing result of one accepted command and moves the channels on
      function void advance_channels(mode_type op, logic [CH_IN_W-1:0] ch,
                                     logic [TICK_W-1:0] ivl, logic [TICK_W-1:0] now);
         timing_type        res;
         longint            need;
         longint            span;
         logic [TICK_W-1:0] diff;
         logic [TPU_W-1:0]  rate;
         res.done = 1'b0;
         res.whole_us = '0;
         res.rem_ticks = '0;
         rate = (ticks_per_us == '0) ? 8'd1 : ticks_per_us;
         need = {40'd0, ivl} * {56'd0, rate};
         diff = chan_start[ch] - now;
         case (op)
            MODE_CHECK: begin
               if (ivl > long_thresh) begin
                  if (chan_last[ch] < now && chan_wraps[ch] != WRAP_MAX) begin
                     chan_wraps[ch] = chan_wraps[ch] + 1'b1;
                  end
                  span = {24'd0, chan_wraps[ch], 24'd0} + {40'd0, chan_start[ch]}
                         - {40'd0, now};
                  if (span >= need) begin
                     restart_chan(ch, now);
                     res.done = 1'b1;
                  end else begin
                     chan_last[ch] = now;
                  end
               end else begin
                  span = {40'd0, diff};
                  chan_wraps[ch] = '0;
                  chan_last[ch] = now;
                  if (span >= need) begin
                     chan_start[ch] = now;
                     res.done = 1'b1;
                  end
               end
            end
            MODE_READ: begin
               res.whole_us = diff / rate;
               res.rem_ticks = TPU_W'(diff % rate);
               chan_start[ch] = now;
            end
            MODE_CLEAR_ONE: begin
               restart_chan(ch, now);
            end
            default: begin
               for (int i = 0; i < CHANNELS_DEF; i++) restart_chan(i, now);
            end
         endcase
         due_timings.push_back(res);
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      endfunction

      function void compare_timing(logic done, logic [TICK_W-1:0] us, logic [TPU_W-1:0] rem);
         timing_type want;
         if (due_timings.size() == 0) begin
            flag("unexpected result, interval_done", 32'd0, {31'd0, done});
            return;
         end
         want = due_timings.pop_front();
         if (done !== want.done) flag("interval_done", {31'd0, want.done}, {31'd0, done});
         if (us !== want.whole_us) flag("elapsed_us", {8'd0, want.whole_us}, {8'd0, us});
         if (rem !== want.rem_ticks) begin
            flag("elapsed_rem_ticks", {24'd0, want.rem_ticks}, {24'd0, rem});
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic [1:0]           req_mode;
   logic [CH_IN_W-1:0]   req_channel;
   logic [TICK_W-1:0]    req_interval_us;
   logic [TICK_W-1:0]    req_tick_now;
   logic                 rsp_valid;
   logic                 rsp_interval_done;
   logic [TICK_W-1:0]    rsp_elapsed_us;
   logic [TPU_W-1:0]     rsp_elapsed_rem_ticks;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_data;

   timer_scoreboard   board = new();
   int                quiet_cycles = 0;
   bit                gaps_on;
   logic [TICK_W-1:0] counter_now;

   multi_channel_elapsed_timer DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_mode              (req_mode),
      .req_channel           (req_channel),
      .req_interval_us       (req_interval_us),
      .req_tick_now          (req_tick_now),
      .rsp_valid             (rsp_valid),
      .rsp_interval_done     (rsp_interval_done),
      .rsp_elapsed_us        (rsp_elapsed_us),
      .rsp_elapsed_rem_ticks (rsp_elapsed_rem_ticks),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         board.compare_timing(rsp_interval_done, rsp_elapsed_us, rsp_elapsed_rem_ticks);
      end
   end

   // cycles with no transfer on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("multi_channel_elapsed_timer verification failed");
      $finish;
   end

   task automatic issue_command(mode_type op, logic [CH_IN_W-1:0] ch,
                                logic [TICK_W-1:0] ivl, logic [TICK_W-1:0] now);
      if (gaps_on && $urandom_range(0, 99) < 33) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= op;
      req_channel <= ch;
      req_interval_us <= ivl;
      req_tick_now <= now;
      do @(posedge clock); while (busy);
      board.advance_channels(op, ch, ivl, now);
   endtask

   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (board.due_timings.size() != 0 || busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_timer(logic [TPU_W-1:0] rate, logic [TICK_W-1:0] thresh);
      bit                flip;
      csr_index_type     idx;
      logic [TICK_W-1:0] value;
      flip = $urandom_range(0, 1);
      for (int k = 0; k < 2; k++) begin
         if ((k == 0) ^ flip) begin
            idx = CSR_TICKS_PER_US;
            value = {16'($urandom), rate};
         end else begin
            idx = CSR_LONG_THRESH;
            value = thresh;
         end
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data <= value;
         do @(posedge clock); while (!csr_ready);
         board.set_register(idx, value);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly a down-counter moving on by plausible steps, sometimes jumping anywhere
   task automatic random_item();
      int                pick;
      mode_type          op;
      logic [CH_IN_W-1:0] ch;
      logic [TICK_W-1:0] ivl;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         counter_now = counter_now - TICK_W'($urandom_range(0, 20000));
      end else if (pick < 85) begin
         counter_now = counter_now - TICK_W'($urandom);
      end else begin
         counter_now = TICK_W'($urandom);
      end
      pick = $urandom_range(0, 99);
      op = (pick < 55) ? MODE_CHECK : (pick < 80) ? MODE_READ :
           (pick < 92) ? MODE_CLEAR_ONE : MODE_CLEAR_ALL;
      ch = $urandom_range(0, 1) ? CH_IN_W'($urandom_range(0, 3)) : CH_IN_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         ivl = TICK_W'($urandom_range(0, 64));
      end else if (pick < 60) begin
         ivl = board.long_thresh - 24'd1 + TICK_W'($urandom_range(0, 2));
      end else if (pick < 80) begin
         ivl = TICK_W'($urandom);
      end else begin
         ivl = TICK_W'($urandom_range(0, 24'h1FFFF));
      end
      issue_command(op, ch, ivl, counter_now);
   endtask

   initial begin
      logic [TPU_W-1:0]  rate;
      logic [TICK_W-1:0] thresh;
      reset <= 1'b1;
      start <= 1'b0;
      req_mode <= MODE_CHECK;
      req_channel <= '0;
      req_interval_us <= '0;
      req_tick_now <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_TICKS_PER_US;
      csr_data <= '0;
      gaps_on = 1'b1;
      counter_now = TICK_TOP;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults, wrap of the counter, threshold edge, long interval wraps
      issue_command(MODE_READ, 4'd3, 24'd0, 24'hABCDEF);
      issue_command(MODE_CLEAR_ALL, 4'hF, TICK_TOP, TICK_TOP);
      issue_command(MODE_CHECK, 4'd0, 24'd0, TICK_TOP);
      issue_command(MODE_CHECK, 4'd0, 24'd1, TICK_TOP - 24'd100);
      issue_command(MODE_CHECK, 4'd0, 24'd1, TICK_TOP - 24'd168);
      issue_command(MODE_READ, 4'hF, 24'd0, 24'd0);
      issue_command(MODE_READ, 4'hF, 24'd0, TICK_TOP);
      issue_command(MODE_CLEAR_ONE, 4'd5, 24'd0, 24'h123456);
      issue_command(MODE_CHECK, 4'd5, TICK_TOP, 24'h100000);
      issue_command(MODE_CHECK, 4'd5, 24'd100000, 24'h200000);
      issue_command(MODE_CHECK, 4'd5, 24'd100000, 24'h300000);
      issue_command(MODE_CHECK, 4'd5, 24'd90000, 24'h2F0000);
      issue_command(MODE_CHECK, 4'd5, 24'd90001, 24'h400000);
      issue_command(MODE_READ, 4'd5, TICK_TOP, 24'h000000);
      issue_command(MODE_CHECK, 4'd7, 24'd0, 24'd0);
      issue_command(MODE_CLEAR_ALL, 4'd0, 24'd0, 24'd0);
      issue_command(MODE_CHECK, 4'd9, TICK_TOP, TICK_TOP);
      issue_command(MODE_CHECK, 4'd9, TICK_TOP, 24'd1);
      issue_command(MODE_CLEAR_ONE, 4'hF, TICK_TOP, 24'd0);
      issue_command(MODE_READ, 4'hA, 24'd0, 24'h555555);

      for (int p = 0; p < PHASES; p++) begin
         settle();
         rate = PHASE_RATE[p];
         thresh = PHASE_THRESH[p];
         if (p == 4) begin
            rate = TPU_W'($urandom_range(0, 255));
            thresh = TICK_W'($urandom);
         end else if (p == 6) begin
            rate = TPU_W'($urandom_range(0, 255));
            thresh = TICK_W'($urandom_range(0, 200000));
         end
         program_timer(rate, thresh);
         gaps_on = (p != 2);
         for (int n = 0; n < PHASE_ITEMS; n++) random_item();
      end

      start <= 1'b0;
      do @(posedge clock); while (board.due_timings.size() != 0);
      repeat (40) @(posedge clock);
      if (board.errors == 0) begin
         $display("multi_channel_elapsed_timer verification clean");
      end else begin
         $display("multi_channel_elapsed_timer verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/mcet_pkg.sv
sv/mcet_ram.sv
sv/multi_channel_elapsed_timer.sv
tb/multi_channel_elapsed_timer_tb.sv
